>>> rtl/tcfs_pkg.sv
`default_nettype none
// tcfs_pkg: widths, codes, payload and configuration types for the triangle
// cull and flat shade pipeline. Depends on nothing.
package tcfs_pkg;

  localparam int CoordW    = 16;
  localparam int CamW      = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int CrossW    = 2 * DiffW;
  localparam int NormW     = CrossW + 1;
  localparam int DistW     = CoordW + 3;
  localparam int NdW       = NormW + DistW;
  localparam int DotW      = NdW + 2;
  localparam int UnitW     = 15;
  localparam int ShiftW    = $clog2(NormW - UnitW + 1);
  localparam int LightW    = 16;
  localparam int ProjW     = 2 * (UnitW + 1);
  localparam int ProjSumW  = ProjW + 2;
  localparam int PosW      = 32;
  localparam int SqW       = 2 * UnitW;
  localparam int SqSumW    = SqW + 2;
  localparam int FracW     = 16;
  localparam int RadW      = SqSumW + FracW;
  localparam int RootW     = RadW / 2;
  localparam int ScaleW    = 10;
  localparam int NumW      = PosW + ScaleW;
  localparam int QuotW     = 18;
  localparam int GainW     = 9;
  localparam int DiffuseW  = GainW + QuotW;
  localparam int ShadeW    = DiffuseW + 1;
  localparam int ChanW     = 8;
  localparam int ChanProdW = ChanW + ShadeW;
  localparam int ShadeFrW  = 24;
  localparam int ColorW    = 32;
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 3;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  localparam logic signed [CamW-1:0]   CamReset    = 16'sd0;
  localparam logic signed [LightW-1:0] LightXReset = -16'sd6554;
  localparam logic signed [LightW-1:0] LightYReset = 16'sd11469;
  localparam logic signed [LightW-1:0] LightZReset = -16'sd9830;
  localparam logic [GainW-1:0]         AmbReset    = 9'd141;
  localparam logic [GainW-1:0]         DifReset    = 9'd115;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCamX    = 3'd0,
    CfgCamY    = 3'd1,
    CfgLightX  = 3'd2,
    CfgLightY  = 3'd3,
    CfgLightZ  = 3'd4,
    CfgAmbient = 3'd5,
    CfgDiffuse = 3'd6
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
    logic [ColorW-1:0] base_color;
  } tri_in_t;

  typedef struct packed {
    coord_t out_a_x;
    coord_t out_a_y;
    coord_t out_a_z;
    coord_t out_b_x;
    coord_t out_b_y;
    coord_t out_b_z;
    coord_t out_c_x;
    coord_t out_c_y;
    coord_t out_c_z;
    logic [ColorW-1:0] shaded_color;
  } tri_out_t;

  typedef struct packed {
    logic signed [CamW-1:0]   cam_x;
    logic signed [CamW-1:0]   cam_y;
    logic signed [LightW-1:0] light_x;
    logic signed [LightW-1:0] light_y;
    logic signed [LightW-1:0] light_z;
    logic [GainW-1:0]         ambient;
    logic [GainW-1:0]         diffuse;
  } cfg_t;

  // Sidecar of the square root stages.
  typedef struct packed {
    tri_in_t         prim;
    logic [PosW-1:0] proj;
    logic            zero_term;
  } sq_side_t;

  // Sidecar of the divider stages.
  typedef struct packed {
    tri_in_t prim;
    logic    zero_term;
  } dv_side_t;

endpackage
`default_nettype wire

>>> rtl/tcfs_geom.sv
`default_nettype none
// tcfs_geom: nine-stage front end: face normal, back-face test, normal
// scaling and the light and length dot products. Uses tcfs_pkg.
module tcfs_geom (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tcfs_pkg::tri_in_t  tri_i,
  input  tcfs_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output tcfs_pkg::sq_side_t side_o,
  output logic [tcfs_pkg::RadW-1:0] rad_o
);
  import tcfs_pkg::*;

  localparam int Depth = 9;
  localparam int CullStage = 4;

  logic [Depth-1:0] v_q, v_d;
  tri_in_t prim_q [Depth];

  logic signed [DiffW-1:0]  u_d [3], w_d [3], u_q [3], w_q [3];
  logic signed [DistW-1:0]  d_d [3], d1_q [3], d2_q [3], d3_q [3];
  logic signed [CrossW-1:0] cr_d [6], cr_q [6];
  logic signed [NormW-1:0]  n_d [3], n3_q [3], n4_q [3];
  logic signed [NdW-1:0]    nd_d [3], nd_q [3];
  logic signed [DotW-1:0]   dot_d;
  logic                     keep_d;
  logic [NormW-1:0]         mag_d [3], mag5_q [3], mag6_q [3];
  logic [2:0]               sgn5_q, sgn6_q, sgn7_q;
  logic [NormW-1:0]         orv_d;
  logic [ShiftW-1:0]        k_d, k6_q;
  logic                     zero6_q, zero7_q, zero8_q, zero9_q, zt_d;
  logic [NormW-1:0]         shf_d [3];
  logic [UnitW-1:0]         m_d [3], m7_q [3];
  logic signed [UnitW:0]    np_d [3], np7_q [3];
  logic signed [LightW-1:0] lv [3];
  logic signed [ProjW-1:0]  pl_d [3], pl8_q [3];
  logic [SqW-1:0]           mm_d [3], mm8_q [3];
  logic signed [ProjSumW-1:0] p_d, p9_q;
  logic [SqSumW-1:0]        s_d, s9_q;

  // Stage 1: edge vectors and the scaled camera-to-centroid vector.
  always_comb begin
    u_d[0] = DiffW'(tri_i.vertex_b_x) - DiffW'(tri_i.vertex_a_x);
    u_d[1] = DiffW'(tri_i.vertex_b_y) - DiffW'(tri_i.vertex_a_y);
    u_d[2] = DiffW'(tri_i.vertex_b_z) - DiffW'(tri_i.vertex_a_z);
    w_d[0] = DiffW'(tri_i.vertex_c_x) - DiffW'(tri_i.vertex_a_x);
    w_d[1] = DiffW'(tri_i.vertex_c_y) - DiffW'(tri_i.vertex_a_y);
    w_d[2] = DiffW'(tri_i.vertex_c_z) - DiffW'(tri_i.vertex_a_z);
    d_d[0] = (DistW'(cfg_i.cam_x) <<< 1) + DistW'(cfg_i.cam_x)
           - (DistW'(tri_i.vertex_a_x) + DistW'(tri_i.vertex_b_x)
              + DistW'(tri_i.vertex_c_x));
    d_d[1] = (DistW'(cfg_i.cam_y) <<< 1) + DistW'(cfg_i.cam_y)
           - (DistW'(tri_i.vertex_a_y) + DistW'(tri_i.vertex_b_y)
              + DistW'(tri_i.vertex_c_y));
    d_d[2] = -(DistW'(tri_i.vertex_a_z) + DistW'(tri_i.vertex_b_z)
               + DistW'(tri_i.vertex_c_z));
  end

  // Stage 2: cross product terms.
  always_comb begin
    cr_d[0] = u_q[1] * w_q[2];
    cr_d[1] = u_q[2] * w_q[1];
    cr_d[2] = u_q[2] * w_q[0];
    cr_d[3] = u_q[0] * w_q[2];
    cr_d[4] = u_q[0] * w_q[1];
    cr_d[5] = u_q[1] * w_q[0];
  end

  // Stage 3: normal; stage 4: normal times view vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i]  = NormW'(cr_q[2*i]) - NormW'(cr_q[2*i+1]);
      nd_d[i] = n3_q[i] * d3_q[i];
    end
  end

  // Stage 5: view dot product and cull decision, normal magnitudes.
  always_comb begin
    dot_d  = DotW'(nd_q[0]) + DotW'(nd_q[1]) + DotW'(nd_q[2]);
    keep_d = !dot_d[DotW-1] && (dot_d != '0);
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = n4_q[i][NormW-1] ? NormW'(-n4_q[i]) : NormW'(n4_q[i]);
    end
  end

  // Stage 6: the largest magnitude has the same top bit as the OR of all.
  always_comb begin
    orv_d = mag5_q[0] | mag5_q[1] | mag5_q[2];
    k_d   = '0;
    for (int b = UnitW; b < NormW; b++) begin
      if (orv_d[b]) begin
        k_d = ShiftW'(b - UnitW + 1);
      end
    end
  end

  // Stage 7: scaled normal; stage 8: products; stage 9: sums.
  always_comb begin
    lv[0] = cfg_i.light_x;
    lv[1] = cfg_i.light_y;
    lv[2] = cfg_i.light_z;
    for (int i = 0; i < 3; i++) begin
      shf_d[i] = mag6_q[i] >> k6_q;
      m_d[i]   = shf_d[i][UnitW-1:0];
      np_d[i]  = sgn6_q[i] ? -$signed({1'b0, m_d[i]}) : $signed({1'b0, m_d[i]});
      pl_d[i]  = np7_q[i] * lv[i];
      mm_d[i]  = m7_q[i] * m7_q[i];
    end
    p_d  = ProjSumW'(pl8_q[0]) + ProjSumW'(pl8_q[1]) + ProjSumW'(pl8_q[2]);
    s_d  = SqSumW'(mm8_q[0]) + SqSumW'(mm8_q[1]) + SqSumW'(mm8_q[2]);
    zt_d = zero8_q || p_d[ProjSumW-1] || (p_d == '0);
  end

  always_comb begin
    v_d = {v_q[Depth-2:0], valid_i};
    v_d[CullStage] = v_q[CullStage-1] && keep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prim_q[0] <= tri_i;
      for (int s = 1; s < Depth; s++) begin
        prim_q[s] <= prim_q[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        u_q[i]    <= u_d[i];
        w_q[i]    <= w_d[i];
        d1_q[i]   <= d_d[i];
        d2_q[i]   <= d1_q[i];
        d3_q[i]   <= d2_q[i];
        n3_q[i]   <= n_d[i];
        n4_q[i]   <= n3_q[i];
        nd_q[i]   <= nd_d[i];
        mag5_q[i] <= mag_d[i];
        mag6_q[i] <= mag5_q[i];
        np7_q[i]  <= np_d[i];
        m7_q[i]   <= m_d[i];
        pl8_q[i]  <= pl_d[i];
        mm8_q[i]  <= mm_d[i];
        sgn5_q[i] <= n4_q[i][NormW-1];
      end
      for (int j = 0; j < 6; j++) begin
        cr_q[j] <= cr_d[j];
      end
      sgn6_q  <= sgn5_q;
      sgn7_q  <= sgn6_q;
      k6_q    <= k_d;
      zero6_q <= (orv_d == '0);
      zero7_q <= zero6_q;
      zero8_q <= zero7_q;
      zero9_q <= zt_d;
      p9_q    <= p_d;
      s9_q    <= s_d;
    end
  end

  assign valid_o          = v_q[Depth-1];
  assign side_o.prim      = prim_q[Depth-1];
  assign side_o.proj      = p9_q[PosW-1:0];
  assign side_o.zero_term = zero9_q;
  assign rad_o            = {s9_q, FracW'(0)};

`ifndef SYNTHESIS
  // A lit face always has a nonzero scaled normal, so the root is never zero.
  a_lit_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_o.zero_term |-> rad_o != '0)
    else $error("lit triangle with zero normal length");
  // Sign bits used by the scaling stage are carried unchanged into sgn7_q.
  a_sign_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && v_q[5] |=> sgn7_q == $past(sgn6_q))
    else $error("normal sign lost in scaling stage");
`endif

endmodule
`default_nettype wire

>>> rtl/tcfs_isqrt.sv
`default_nettype none
// tcfs_isqrt: integer square root, one result bit per pipeline stage,
// carrying the triangle sidecar alongside. Uses tcfs_pkg.
module tcfs_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tcfs_pkg::sq_side_t side_i,
  input  logic [tcfs_pkg::RadW-1:0] rad_i,
  output logic               valid_o,
  output tcfs_pkg::sq_side_t side_o,
  output logic [tcfs_pkg::RootW-1:0] root_o
);
  import tcfs_pkg::*;

  localparam int RemW = RootW + 3;

  logic [RootW-1:0] v_q;
  sq_side_t         side_q [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RadW-1:0]  rad_q  [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_step
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic [RootW-1:0] root_in;
    logic [RadW-1:0]  rad_in;
    sq_side_t         side_in;
    logic             v_in, take;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = v_q[s-1];
    end

    // The remainder never exceeds twice the partial root, so its top two bits
    // are always clear before the shift.
    always_comb begin
      rem_sh = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
      trial  = RemW'({root_in, 2'b01});
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? rem_sh - trial : rem_sh;
        root_q[s] <= {root_in[RootW-2:0], take};
        rad_q[s]  <= rad_in << 2;
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign side_o  = side_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule
`default_nettype wire

>>> rtl/tcfs_div.sv
`default_nettype none
// tcfs_div: restoring divider, one quotient bit per pipeline stage, for the
// Lambert term. Uses tcfs_pkg.
module tcfs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tcfs_pkg::dv_side_t side_i,
  input  logic [tcfs_pkg::NumW-1:0]  num_i,
  input  logic [tcfs_pkg::RootW-1:0] den_i,
  output logic               valid_o,
  output tcfs_pkg::dv_side_t side_o,
  output logic [tcfs_pkg::QuotW-1:0] quot_o
);
  import tcfs_pkg::*;

  logic [QuotW-1:0] v_q;
  dv_side_t         side_q [QuotW];
  logic [RootW-1:0] rem_q  [QuotW];
  logic [RootW-1:0] den_q  [QuotW];
  logic [QuotW-1:0] low_q  [QuotW];
  logic [QuotW-1:0] q_q    [QuotW];

  for (genvar s = 0; s < QuotW; s++) begin : g_step
    logic [RootW-1:0] rem_in, den_in;
    logic [QuotW-1:0] low_in, q_in;
    logic [RootW:0]   rem_sh, diff;
    dv_side_t         side_in;
    logic             v_in, ge;

    if (s == 0) begin : g_first
      assign rem_in  = num_i[NumW-1:QuotW];
      assign low_in  = num_i[QuotW-1:0];
      assign q_in    = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign q_in    = q_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = v_q[s-1];
    end

    always_comb begin
      rem_sh = {rem_in, low_in[QuotW-1]};
      diff   = rem_sh - {1'b0, den_in};
      ge     = (rem_sh >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[RootW-1:0] : rem_sh[RootW-1:0];
        q_q[s]    <= {q_in[QuotW-2:0], ge};
        low_q[s]  <= low_in << 1;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end
  end

  assign valid_o = v_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];
  assign quot_o  = q_q[QuotW-1];

`ifndef SYNTHESIS
  // For a lit face the term is bounded by four times the light length, so
  // the quotient always fits.
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !side_i.zero_term |-> num_i[NumW-1:QuotW] < den_i)
    else $error("Lambert quotient overflows divider");
`endif

endmodule
`default_nettype wire

>>> rtl/tcfs_shade.sv
`default_nettype none
// tcfs_shade: four-stage color scaling by ambient plus weighted Lambert
// term, with channel saturation and the output register. Uses tcfs_pkg.
module tcfs_shade (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tcfs_pkg::tri_in_t  prim_i,
  input  logic               zero_term_i,
  input  logic [tcfs_pkg::QuotW-1:0] quot_i,
  input  tcfs_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output tcfs_pkg::tri_out_t data_o
);
  import tcfs_pkg::*;

  localparam int Depth = 4;
  localparam int SatW  = ChanProdW - ShadeFrW;

  logic [Depth-1:0]     v_q;
  tri_in_t              prim_q [Depth-1];
  logic [QuotW-1:0]     term_d;
  logic [DiffuseW-1:0]  dg_d, dg1_q;
  logic [ShadeW-1:0]    gain_d, gain2_q;
  logic [ChanProdW-1:0] cp_d [3], cp3_q [3];
  logic [SatW-1:0]      lvl_d [3];
  logic [ChanW-1:0]     ch_d [3];
  tri_out_t             out_d, out_q;

  always_comb begin
    term_d = zero_term_i ? '0 : quot_i;
    dg_d   = cfg_i.diffuse * term_d;
    gain_d = ShadeW'({cfg_i.ambient, FracW'(0)}) + ShadeW'(dg1_q);
    for (int i = 0; i < 3; i++) begin
      cp_d[i]  = prim_q[1].base_color[ChanW*i +: ChanW] * gain2_q;
      lvl_d[i] = cp3_q[i][ChanProdW-1:ShadeFrW];
      ch_d[i]  = (lvl_d[i] > SatW'(ChanMax)) ? ChanMax : lvl_d[i][ChanW-1:0];
    end
    out_d.out_a_x      = prim_q[2].vertex_a_x;
    out_d.out_a_y      = prim_q[2].vertex_a_y;
    out_d.out_a_z      = prim_q[2].vertex_a_z;
    out_d.out_b_x      = prim_q[2].vertex_b_x;
    out_d.out_b_y      = prim_q[2].vertex_b_y;
    out_d.out_b_z      = prim_q[2].vertex_b_z;
    out_d.out_c_x      = prim_q[2].vertex_c_x;
    out_d.out_c_y      = prim_q[2].vertex_c_y;
    out_d.out_c_z      = prim_q[2].vertex_c_z;
    out_d.shaded_color = {prim_q[2].base_color[ColorW-1 -: ChanW],
                          ch_d[2], ch_d[1], ch_d[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prim_q[0] <= prim_i;
      prim_q[1] <= prim_q[0];
      prim_q[2] <= prim_q[1];
      dg1_q     <= dg_d;
      gain2_q   <= gain_d;
      for (int i = 0; i < 3; i++) begin
        cp3_q[i] <= cp_d[i];
      end
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[Depth-1];
  assign data_o  = out_q;

`ifndef SYNTHESIS
  // Alpha of the result is the alpha of the transaction that produced it.
  a_alpha_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && v_q[Depth-2] |=> valid_o
      && data_o.shaded_color[ColorW-1 -: ChanW]
         == $past(prim_q[2].base_color[ColorW-1 -: ChanW]))
    else $error("alpha changed by shading");
`endif

endmodule
`default_nettype wire

>>> rtl/triangle_cull_flat_shade.sv
`default_nettype none
// Back-face culling with Lambert flat shading, one triangle per clock.
// The path from an accepted transaction to its result runs through 9 geometry
// stages, 24 square root stages, 18 divider stages and 4 shading stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits on a stalled output. Culled triangles leave a bubble.
// Reset clears all valid bits and loads the default camera, light and gains.
module triangle_cull_flat_shade (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcfs_pkg::tri_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcfs_pkg::tri_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [tcfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tcfs_pkg::CfgW-1:0]    cfg_wdata_i
);
  import tcfs_pkg::*;

  cfg_t     cfg_q;
  logic     en;
  logic     geo_valid, sq_valid, dv_valid;
  sq_side_t geo_side, sq_side;
  dv_side_t dv_in_side, dv_side;
  logic [RadW-1:0]  rad;
  logic [RootW-1:0] root;
  logic [QuotW-1:0] quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_x   <= CamReset;
      cfg_q.cam_y   <= CamReset;
      cfg_q.light_x <= LightXReset;
      cfg_q.light_y <= LightYReset;
      cfg_q.light_z <= LightZReset;
      cfg_q.ambient <= AmbReset;
      cfg_q.diffuse <= DifReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCamX:    cfg_q.cam_x   <= cfg_wdata_i;
        CfgCamY:    cfg_q.cam_y   <= cfg_wdata_i;
        CfgLightX:  cfg_q.light_x <= cfg_wdata_i;
        CfgLightY:  cfg_q.light_y <= cfg_wdata_i;
        CfgLightZ:  cfg_q.light_z <= cfg_wdata_i;
        CfgAmbient: cfg_q.ambient <= cfg_wdata_i[GainW-1:0];
        CfgDiffuse: cfg_q.diffuse <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Every stage advances unless a finished result is held by the consumer.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  tcfs_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tri_i   (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (geo_valid),
    .side_o  (geo_side),
    .rad_o   (rad)
  );

  tcfs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_valid),
    .side_i  (geo_side),
    .rad_i   (rad),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (root)
  );

  assign dv_in_side.prim      = sq_side.prim;
  assign dv_in_side.zero_term = sq_side.zero_term;

  tcfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .side_i  (dv_in_side),
    .num_i   ({sq_side.proj, ScaleW'(0)}),
    .den_i   (root),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (quot)
  );

  tcfs_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (dv_valid),
    .prim_i      (dv_side.prim),
    .zero_term_i (dv_side.zero_term),
    .quot_i      (quot),
    .cfg_i       (cfg_q),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o)
  );

endmodule
`default_nettype wire
